// ===== sv/tsa_pkg.sv =====
// shared types, constants and sequence-compare helpers for the tcp segment analyzer
// no dependencies
`default_nettype none
package tsa_pkg;

  localparam int MAX_SACK_BLOCKS = 4;
  localparam int SACK_CNT_W = $clog2(MAX_SACK_BLOCKS + 1);
  localparam int SACK_IDX_W = (MAX_SACK_BLOCKS > 1) ? $clog2(MAX_SACK_BLOCKS) : 1;

  localparam logic [23:0] REORDER_WIN_RST = 24'd30000;
  localparam logic [23:0] FAST_SLACK_RST  = 24'd20000;

  localparam logic [7:0] CFG_REORDER_WIN = 8'd0;
  localparam logic [7:0] CFG_FAST_SLACK  = 8'd1;

  localparam logic [14:0] F_LOST       = 15'h0002;
  localparam logic [14:0] F_ACK_LOST   = 15'h0004;
  localparam logic [14:0] F_KEEP_ALIVE = 15'h0008;
  localparam logic [14:0] F_DUP_ACK    = 15'h0010;
  localparam logic [14:0] F_ZERO_WIN   = 15'h0020;
  localparam logic [14:0] F_PROBE      = 15'h0040;
  localparam logic [14:0] F_PROBE_ACK  = 15'h0080;
  localparam logic [14:0] F_KA_ACK     = 15'h0100;
  localparam logic [14:0] F_WIN_UPDATE = 15'h0800;
  localparam logic [14:0] F_WIN_FULL   = 15'h1000;
  localparam logic [14:0] F_USED_MASK  = 15'h19FE;

  localparam logic [2:0] RC_NONE  = 3'd0;
  localparam logic [2:0] RC_ACKED = 3'd1;
  localparam logic [2:0] RC_FAST  = 3'd2;
  localparam logic [2:0] RC_OOO   = 3'd3;
  localparam logic [2:0] RC_PLAIN = 3'd4;

  localparam logic [7:0] SHIFT_UNKNOWN = 8'd255;
  localparam logic [7:0] SHIFT_MAX     = 8'd14;

  typedef struct packed {
    logic        func;
    logic        direction;
    logic [3:0]  tcp_flags;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [15:0] window_raw;
    logic [7:0]  win_scale_opt;
    logic [15:0] payload_len;
    logic [47:0] time_us;
    logic [31:0] sack_left;
    logic [31:0] sack_right;
  } item_t;

  function automatic logic seq_lt(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] d;
    d = x - y;
    return d[31];
  endfunction

  function automatic logic seq_gt(input logic [31:0] x, input logic [31:0] y);
    return seq_lt(y, x);
  endfunction

  function automatic logic seq_le(input logic [31:0] x, input logic [31:0] y);
    return (x == y) || seq_lt(x, y);
  endfunction

  function automatic logic seq_ge(input logic [31:0] x, input logic [31:0] y);
    return (x == y) || seq_lt(y, x);
  endfunction

endpackage
`default_nettype wire

// ===== sv/tsa_front.sv =====
// front end: accepts header and sack transactions into a two-entry queue
// depends on tsa_pkg
`default_nettype none
module tsa_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire tsa_pkg::item_t in_item,
  output logic              q_valid,
  output tsa_pkg::item_t    q_item,
  input  wire               q_pop
);
  import tsa_pkg::*;

  item_t       slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> (cnt_r == 2'd2))
    else $error("full queue changed without pop");
`endif

endmodule
`default_nettype wire

// ===== sv/tsa_back.sv =====
// back end: per-direction sequence state, analysis flags and retransmission class
// depends on tsa_pkg
`default_nettype none
module tsa_back (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               q_valid,
  input  wire tsa_pkg::item_t q_item,
  output logic              q_pop,
  input  wire               cfg_we,
  input  wire  [7:0]        cfg_index,
  input  wire  [23:0]       cfg_data,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [14:0]       out_analysis_flags,
  output logic [2:0]        out_retrans_class,
  output logic              out_rtt_valid,
  output logic [47:0]       out_first_rtt_us
);
  import tsa_pkg::*;

  logic [23:0] reorder_win_r, fast_slack_r;

  logic [31:0] next_seq_r [2], next_seq_nxt [2];
  logic [47:0] next_time_r [2], next_time_nxt [2];
  logic [31:0] max_ack_r [2], max_ack_nxt [2];
  logic [29:0] swin_r [2], swin_nxt [2];
  logic [31:0] last_ack_r [2], last_ack_nxt [2];
  logic [47:0] ack_time_r [2], ack_time_nxt [2];
  logic [7:0]  wshift_r [2], wshift_nxt [2];
  logic [14:0] lflags_r [2], lflags_nxt [2];
  logic [15:0] dup_r [2], dup_nxt [2];
  logic [SACK_CNT_W-1:0] scnt_r [2], scnt_nxt [2];
  logic [31:0] sl_r [2][MAX_SACK_BLOCKS];
  logic [31:0] sr_r [2][MAX_SACK_BLOCKS];
  logic [31:0] pl_r [MAX_SACK_BLOCKS];
  logic [31:0] pr_r [MAX_SACK_BLOCKS];
  logic [SACK_CNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [47:0] syn_time_r, syn_time_nxt;
  logic [47:0] rtt_r, rtt_nxt;

  logic        out_valid_r;
  logic [14:0] o_flags_r;
  logic [2:0]  o_cls_r;
  logic        o_rttv_r;
  logic [47:0] o_rtt_r;

  logic        fire, seg, sack_wr;
  logic        f, r;
  logic        syn, ackf, fin, rst, sfr, sf;
  logic [31:0] seq, ack, len32, inc32, seg_end, nseq, seq_len;
  logic [15:0] len;
  logic [47:0] now;
  logic [29:0] win;
  logic [7:0]  sh_f;
  logic [3:0]  sh_amt;
  logic [14:0] flags;
  logic [2:0]  cls;
  logic        rttv, probe, acked, retx;
  logic [47:0] rtt_cur, thres, t1, t2;
  logic [48:0] lim;
  logic        t1_ok, t2_ok;

  assign fire    = q_valid && (!out_valid_r || !out_stall);
  assign q_pop   = fire;
  assign seg     = fire && q_item.func;
  assign sack_wr = fire && !q_item.func && (pcnt_r < SACK_CNT_W'(MAX_SACK_BLOCKS));

  always_comb begin
    f       = q_item.direction;
    r       = ~f;
    syn     = q_item.tcp_flags[0];
    ackf    = q_item.tcp_flags[1];
    fin     = q_item.tcp_flags[2];
    rst     = q_item.tcp_flags[3];
    sfr     = syn || fin || rst;
    sf      = syn || fin;
    seq     = q_item.seq_num;
    ack     = q_item.ack_num;
    len     = q_item.payload_len;
    len32   = {16'd0, len};
    inc32   = len32 + {31'd0, sf};
    seg_end = seq + inc32;
    nseq    = seg_end;
    seq_len = seq + len32;
    now     = q_item.time_us;

    for (int d = 0; d < 2; d++) begin
      next_seq_nxt[d]  = next_seq_r[d];
      next_time_nxt[d] = next_time_r[d];
      max_ack_nxt[d]   = max_ack_r[d];
      swin_nxt[d]      = swin_r[d];
      last_ack_nxt[d]  = last_ack_r[d];
      ack_time_nxt[d]  = ack_time_r[d];
      wshift_nxt[d]    = wshift_r[d];
      lflags_nxt[d]    = lflags_r[d];
      dup_nxt[d]       = dup_r[d];
      scnt_nxt[d]      = scnt_r[d];
    end
    syn_time_nxt = syn_time_r;
    rtt_nxt      = rtt_r;
    pcnt_nxt     = pcnt_r + SACK_CNT_W'(sack_wr);

    // window scaling from the shift state before this segment
    sh_f   = wshift_r[f];
    sh_amt = (sh_f > SHIFT_MAX) ? 4'd14 : sh_f[3:0];
    win    = {14'd0, q_item.window_raw};
    if (!syn && wshift_r[f] != SHIFT_UNKNOWN && wshift_r[r] != SHIFT_UNKNOWN) begin
      win = win << sh_amt;
    end
    if (syn) begin
      if (!ackf) begin
        wshift_nxt[f] = q_item.win_scale_opt;
        syn_time_nxt  = now;
      end else if (q_item.win_scale_opt == SHIFT_UNKNOWN || wshift_r[r] == SHIFT_UNKNOWN) begin
        wshift_nxt[f] = 8'd0;
        wshift_nxt[r] = 8'd0;
      end else begin
        wshift_nxt[f] = q_item.win_scale_opt;
      end
    end

    rttv    = !syn && ackf && syn_time_r != 48'd0 && rtt_r == 48'd0;
    rtt_cur = rttv ? (now - syn_time_r) : rtt_r;
    rtt_nxt = rtt_cur;

    flags = 15'd0;
    probe = (len == 16'd1) && (seq == next_seq_r[f]) && (swin_r[r] == 30'd0);
    if (probe) begin
      flags = flags | F_PROBE;
    end else begin
      if (win == 30'd0 && !sfr) flags = flags | F_ZERO_WIN;
      if (next_seq_r[f] != 32'd0 && seq_gt(seq, next_seq_r[f]) && !rst)
        flags = flags | F_LOST;
      if (len <= 16'd1 && seq == next_seq_r[f] - 32'd1 && !sfr)
        flags = flags | F_KEEP_ALIVE;
      if (len == 16'd0 && win != 30'd0 && win != swin_r[f] && seq == next_seq_r[f] &&
          ack == last_ack_r[f] && !sfr)
        flags = flags | F_WIN_UPDATE;
      if (len != 16'd0 && wshift_r[r] != SHIFT_UNKNOWN &&
          seq_len == last_ack_r[r] + {2'd0, swin_r[r]} && !sfr)
        flags = flags | F_WIN_FULL;
      if (len == 16'd0 && win == swin_r[f] && next_seq_r[f] != 32'd0 &&
          ack == last_ack_r[f] && (lflags_r[r] & F_KEEP_ALIVE) != 15'd0 && !sfr) begin
        flags = flags | F_KA_ACK;
      end else if (len == 16'd0 && win == 30'd0 && swin_r[f] == 30'd0 &&
                   seq == next_seq_r[f] && ack == last_ack_r[f] &&
                   (lflags_r[r] & F_PROBE) != 15'd0 && !sfr) begin
        flags = flags | F_PROBE_ACK;
      end else if (len == 16'd0 && win != 30'd0 && win == swin_r[f] &&
                   seq == next_seq_r[f] && ack == last_ack_r[f] && !sfr) begin
        flags = flags | F_DUP_ACK;
        if (dup_r[f] != 16'hFFFF) dup_nxt[f] = dup_r[f] + 16'd1;
      end
    end
    if ((flags & F_DUP_ACK) == 15'd0) dup_nxt[f] = 16'd0;

    if (max_ack_r[r] != 32'd0 && seq_gt(ack, max_ack_r[r]) && ackf) begin
      flags          = flags | F_ACK_LOST;
      max_ack_nxt[r] = next_seq_r[r];
    end

    // acked by cumulative ack or by one of the sack blocks of the other side
    acked = seq_le(seg_end, last_ack_r[r]);
    for (int i = 0; i < MAX_SACK_BLOCKS; i++) begin
      if (SACK_CNT_W'(i) < scnt_r[r] && seq_ge(seq, sl_r[r][i]) &&
          seq_le(seg_end, sr_r[r][i]))
        acked = 1'b1;
    end
    thres = (rtt_cur == 48'd0) ? {24'd0, reorder_win_r} : rtt_cur;
    t1    = now - ack_time_r[r];
    t2    = now - next_time_r[f];
    lim   = f ? ({1'b0, rtt_cur} + {25'd0, fast_slack_r}) : {25'd0, fast_slack_r};
    t1_ok = (now >= ack_time_r[r]) && ({1'b0, t1} < lim);
    t2_ok = (now >= next_time_r[f]) && (t2 < thres);
    retx  = (len != 16'd0 || sf) && next_seq_r[f] != 32'd0 &&
            seq_lt(seq, next_seq_r[f]) && (flags & F_KEEP_ALIVE) == 15'd0;
    cls = RC_NONE;
    if (retx) begin
      if (acked) cls = RC_ACKED;
      else if (dup_r[r] >= 16'd2 && max_ack_r[f] != 32'd0 &&
               seq_lt(seq, max_ack_r[f]) && t1_ok) cls = RC_FAST;
      else if (t2_ok && next_seq_r[f] != seq_len) cls = RC_OOO;
      else cls = RC_PLAIN;
    end

    if ((seq_gt(nseq, next_seq_r[f]) || next_seq_r[f] == 32'd0) && !probe) begin
      next_seq_nxt[f]  = nseq;
      next_time_nxt[f] = now;
    end
    if ((seq == max_ack_r[f] || max_ack_r[f] == 32'd0) && !probe)
      max_ack_nxt[f] = next_seq_nxt[f];

    swin_nxt[f]     = win;
    last_ack_nxt[f] = ack;
    ack_time_nxt[f] = now;
    scnt_nxt[f]     = pcnt_r;
    lflags_nxt[f]   = flags;
    if (seg) pcnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reorder_win_r <= REORDER_WIN_RST;
      fast_slack_r  <= FAST_SLACK_RST;
      for (int d = 0; d < 2; d++) begin
        next_seq_r[d]  <= '0;
        next_time_r[d] <= '0;
        max_ack_r[d]   <= '0;
        swin_r[d]      <= '0;
        last_ack_r[d]  <= '0;
        ack_time_r[d]  <= '0;
        wshift_r[d]    <= SHIFT_UNKNOWN;
        lflags_r[d]    <= '0;
        dup_r[d]       <= '0;
        scnt_r[d]      <= '0;
      end
      pcnt_r      <= '0;
      syn_time_r  <= '0;
      rtt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_REORDER_WIN) reorder_win_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_FAST_SLACK) fast_slack_r <= cfg_data;
      if (seg) begin
        for (int d = 0; d < 2; d++) begin
          next_seq_r[d]  <= next_seq_nxt[d];
          next_time_r[d] <= next_time_nxt[d];
          max_ack_r[d]   <= max_ack_nxt[d];
          swin_r[d]      <= swin_nxt[d];
          last_ack_r[d]  <= last_ack_nxt[d];
          ack_time_r[d]  <= ack_time_nxt[d];
          wshift_r[d]    <= wshift_nxt[d];
          lflags_r[d]    <= lflags_nxt[d];
          dup_r[d]       <= dup_nxt[d];
          scnt_r[d]      <= scnt_nxt[d];
        end
        syn_time_r <= syn_time_nxt;
        rtt_r      <= rtt_nxt;
      end
      if (fire) pcnt_r <= pcnt_nxt;
      if (seg) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sack_wr) begin
      pl_r[pcnt_r[SACK_IDX_W-1:0]] <= q_item.sack_left;
      pr_r[pcnt_r[SACK_IDX_W-1:0]] <= q_item.sack_right;
    end
    if (seg) begin
      for (int i = 0; i < MAX_SACK_BLOCKS; i++) begin
        sl_r[f][i] <= pl_r[i];
        sr_r[f][i] <= pr_r[i];
      end
      o_flags_r <= flags;
      o_cls_r   <= cls;
      o_rttv_r  <= rttv;
      o_rtt_r   <= rtt_cur;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_analysis_flags = o_flags_r;
  assign out_retrans_class  = o_cls_r;
  assign out_rtt_valid      = o_rttv_r;
  assign out_first_rtt_us   = o_rtt_r;

`ifndef SYNTHESIS
  a_cls_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_cls_r <= RC_PLAIN))
    else $error("retransmission class out of range");
  a_flags_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((o_flags_r & ~F_USED_MASK) == 15'd0))
    else $error("reserved analysis flag set");
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= SACK_CNT_W'(MAX_SACK_BLOCKS))
    else $error("pending sack count overflow");
  a_seg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    seg |=> (pcnt_r == '0))
    else $error("segment did not consume pending sack blocks");
`endif

endmodule
`default_nettype wire

// ===== sv/tcp_segment_analyzer_core.sv =====
// an accepted transaction is held in the queue register, then raises out_valid via the output register
// throughput: one transaction per cycle (sack or segment) while out_stall is low; a sack yields no result
// the back end updates all per-direction state at once, which sets the one-per-cycle rate
// reset (synchronous, rst_n low) empties the queue, clears sequence state, window shift unknown
// configuration writes are always accepted; registers reset to 30000 and 20000 us
// depends on tsa_pkg, tsa_front, tsa_back
`default_nettype none
module tcp_segment_analyzer_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_func,
  input  wire         in_direction,
  input  wire  [3:0]  in_tcp_flags,
  input  wire  [31:0] in_seq_num,
  input  wire  [31:0] in_ack_num,
  input  wire  [15:0] in_window_raw,
  input  wire  [7:0]  in_win_scale_opt,
  input  wire  [15:0] in_payload_len,
  input  wire  [47:0] in_time_us,
  input  wire  [31:0] in_sack_left,
  input  wire  [31:0] in_sack_right,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [14:0] out_analysis_flags,
  output logic [2:0]  out_retrans_class,
  output logic        out_rtt_valid,
  output logic [47:0] out_first_rtt_us,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_index,
  input  wire  [23:0] cfg_data
);
  import tsa_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_pop;

  always_comb begin
    in_item.func          = in_func;
    in_item.direction     = in_direction;
    in_item.tcp_flags     = in_tcp_flags;
    in_item.seq_num       = in_seq_num;
    in_item.ack_num       = in_ack_num;
    in_item.window_raw    = in_window_raw;
    in_item.win_scale_opt = in_win_scale_opt;
    in_item.payload_len   = in_payload_len;
    in_item.time_us       = in_time_us;
    in_item.sack_left     = in_sack_left;
    in_item.sack_right    = in_sack_right;
  end

  assign cfg_ready = 1'b1;

  tsa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  tsa_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_analysis_flags (out_analysis_flags),
    .out_retrans_class  (out_retrans_class),
    .out_rtt_valid      (out_rtt_valid),
    .out_first_rtt_us   (out_first_rtt_us)
  );

endmodule
`default_nettype wire
